[sv/ansi_csi_text_console_unit_defines.svh]
// Assertion macros for the ANSI/CSI text console unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef ANSI_CSI_TEXT_CONSOLE_UNIT_DEFINES_SVH
`define ANSI_CSI_TEXT_CONSOLE_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define ACTC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define ACTC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/actc_pkg.sv]
// Shared constants, types and helper functions for the ANSI/CSI text console unit.
// No dependencies.
package actc_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_DRAW   = 3'd0,
        KIND_ERASE  = 3'd1,
        KIND_SCROLL = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_CURSOR = 3'd4
    } kind_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd1;

    localparam logic [8:0] COLS_RESET = 9'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;
    localparam logic [8:0] COLS_MAX   = 9'd256;
    localparam logic [7:0] ROWS_MAX   = 8'd128;

    localparam int         TAB_STOP   = 8;
    localparam logic [8:0] TAB_STOP_W = 9'(TAB_STOP);
    localparam logic [13:0] PARAM_MAX = 14'd9999;
    localparam logic [3:0] MAX_RESULTS = 4'd8;

    // Byte codes
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LBRK = 8'h5B;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_J    = 8'h4A;
    localparam logic [7:0] CH_LF_F = 8'h66;
    localparam logic [7:0] CH_M    = 8'h6D;

    // SGR codes
    localparam logic [13:0] SGR_RESET  = 14'd0;
    localparam logic [13:0] SGR_BRIGHT = 14'd1;
    localparam logic [13:0] SGR_NORMAL = 14'd2;
    localparam logic [13:0] SGR_FG_LO  = 14'd30;
    localparam logic [13:0] SGR_FG_HI  = 14'd37;
    localparam logic [13:0] SGR_BG_LO  = 14'd40;
    localparam logic [13:0] SGR_BG_HI  = 14'd47;
    localparam logic [13:0] SGR_BFG_LO = 14'd90;
    localparam logic [13:0] SGR_BFG_HI = 14'd97;
    localparam logic [13:0] SGR_BBG_LO = 14'd100;
    localparam logic [13:0] SGR_BBG_HI = 14'd107;
    localparam logic [13:0] CLEAR_ALL  = 14'd2;

    localparam logic [3:0] FG_RESET   = 4'd0;
    localparam logic [4:0] BG_DEFAULT = 5'd16;

    typedef struct packed {
        logic       bright;
        logic [3:0] fg;
        logic [4:0] bg;
    } sgr_state_t;

    function automatic logic [8:0] clamp_cols(logic [8:0] v);
        if (v == 9'd0)
            return 9'd1;
        else if (v > COLS_MAX)
            return COLS_MAX;
        else
            return v;
    endfunction

    function automatic logic [7:0] clamp_rows(logic [7:0] v);
        if (v == 8'd0)
            return 8'd1;
        else if (v > ROWS_MAX)
            return ROWS_MAX;
        else
            return v;
    endfunction

    // ANSI colour order to palette order; bright adds eight
    function automatic logic [3:0] palette(logic [2:0] idx, logic bright);
        logic [2:0] p;
        case (idx)
            3'd3:    p = 3'd6;
            3'd4:    p = 3'd3;
            3'd6:    p = 3'd4;
            default: p = idx;
        endcase
        return {bright, p};
    endfunction

    function automatic sgr_state_t sgr_apply(sgr_state_t s, logic [13:0] v);
        sgr_state_t r;
        logic [13:0] d;
        r = s;
        d = '0;
        if (v == SGR_RESET)
        begin
            r.fg = FG_RESET;
            r.bg = BG_DEFAULT;
        end
        else if (v == SGR_BRIGHT)
            r.bright = 1'b1;
        else if (v == SGR_NORMAL)
            r.bright = 1'b0;
        else if (v >= SGR_FG_LO && v <= SGR_FG_HI)
        begin
            d = v - SGR_FG_LO;
            r.fg = palette(d[2:0], s.bright);
        end
        else if (v >= SGR_BG_LO && v <= SGR_BG_HI)
        begin
            d = v - SGR_BG_LO;
            r.bg = {1'b0, palette(d[2:0], 1'b0)};
        end
        else if (v >= SGR_BFG_LO && v <= SGR_BFG_HI)
        begin
            d = v - SGR_BFG_LO;
            r.fg = palette(d[2:0], 1'b1);
        end
        else if (v >= SGR_BBG_LO && v <= SGR_BBG_HI)
        begin
            d = v - SGR_BBG_LO;
            r.bg = {1'b0, palette(d[2:0], 1'b1)};
        end
        return r;
    endfunction

endpackage

[sv/ansi_csi_text_console_unit.sv]
// Throughput: one byte per cycle while the output is not stalled; the result register takes
// one result a cycle, so a tab can give up to MAX_RESULTS results and a wrapping glyph on
// the last row gives a scroll and then a draw, holding the input until they are out.
// Bytes with no result still pass through the input register.
// Reset (rst_n low, asynchronous): parser to ground, cursor home, colours default,
// columns 80, rows 25, both stream registers empty.
`include "ansi_csi_text_console_unit_defines.svh"

module ansi_csi_text_console_unit
    import actc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,    // [7:0] byte_in
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [47:0]            m_tdata,    // cell_col, cell_row, glyph, fg_index,
                                               // bg_index, scroll_lines, zero fill
    output logic [2:0]             m_tuser,    // [2:0] kind
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [8:0]             cfg_data
);

    typedef enum logic [1:0] {
        MODE_GROUND = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2
    } parse_mode_t;

    // Configuration
    logic [8:0]  columns_reg;
    logic [7:0]  rows_reg;

    // Input register
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;

    // Console state
    parse_mode_t mode_reg, mode_next;
    logic        second_reg, second_next;
    logic [13:0] p1_reg, p1_next;
    logic [13:0] p2_reg, p2_next;
    logic        bright_reg, bright_next;
    logic [3:0]  fg_reg, fg_next;
    logic [4:0]  bg_reg, bg_next;
    logic [8:0]  col_reg, col_next;
    logic [6:0]  row_reg, row_next;

    // Multi-result sequencing (tab fill, glyph after scroll)
    logic        busy_reg, busy_next;
    logic        drawpend_reg, drawpend_next;
    logic        tab_reg, tab_next;
    logic [7:0]  glyph_reg, glyph_next;
    logic [3:0]  cnt_reg, cnt_next;

    // Result register
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [8:0]  out_col_reg;
    logic [6:0]  out_row_reg;
    logic [7:0]  out_glyph_reg;
    logic [3:0]  out_fg_reg;
    logic [4:0]  out_bg_reg;
    logic [7:0]  out_lines_reg;
    logic        out_last_reg;

    // Step results
    logic        emit;
    logic        done;
    kind_t       res_kind;
    logic [8:0]  res_col;
    logic [6:0]  res_row;
    logic [7:0]  res_glyph;
    logic [7:0]  res_lines;

    // Glyph placement
    logic        put_do;
    logic [8:0]  put_col;
    logic [3:0]  put_cnt;
    logic [7:0]  put_glyph;
    logic        put_tab;
    logic        put_draw;
    logic [8:0]  draw_col;
    logic [6:0]  draw_row;
    logic        draw_ok;
    logic [8:0]  col_inc;
    logic [3:0]  cnt_inc;

    // Shared arithmetic
    logic        out_free;
    logic        step;
    logic [8:0]  eff_cols;
    logic [7:0]  eff_rows;
    logic [6:0]  last_row;
    logic [8:0]  cols_m1;
    logic [13:0] cnt_p;
    logic [13:0] cnt_m1;
    logic [13:0] x_p;
    logic [13:0] x_m1;
    logic [13:0] adv_cnt;
    logic [14:0] adv_sum;
    logic        adv_scroll;
    logic [14:0] adv_diff;
    logic [7:0]  adv_lines;
    logic [14:0] sum_col;
    logic [8:0]  tab_col;
    logic [7:0]  digit;
    logic [13:0] acc_cur;
    logic [17:0] acc_full;
    logic [13:0] acc_sat;
    sgr_state_t  sgr_cur;
    sgr_state_t  sgr_one;
    sgr_state_t  sgr_two;

    // Configuration write
    logic        cfg_wr;
    logic        cfg_known;
    logic [8:0]  cfg_cols_eff;
    logic [7:0]  cfg_rows_eff;
    logic [6:0]  cfg_last_row;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || (out_free && done);
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_lines_reg, out_bg_reg, out_fg_reg, out_glyph_reg,
                       out_row_reg, out_col_reg};

    assign eff_cols = clamp_cols(columns_reg);
    assign eff_rows = clamp_rows(rows_reg);
    assign last_row = 7'(eff_rows - 8'd1);
    assign cols_m1  = eff_cols - 9'd1;

    assign cnt_p  = (p1_reg == 14'd0) ? 14'd1 : p1_reg;
    assign cnt_m1 = cnt_p - 14'd1;
    assign x_p    = (p2_reg == 14'd0) ? 14'd1 : p2_reg;
    assign x_m1   = x_p - 14'd1;

    // Line advance shared by LF and E; also the downward sum for B
    assign adv_cnt    = (mode_reg == MODE_CSI) ? cnt_p : 14'd1;
    assign adv_sum    = 15'(row_reg) + 15'(adv_cnt);
    assign adv_scroll = adv_sum > 15'(last_row);
    assign adv_diff   = adv_sum - 15'(last_row);
    assign adv_lines  = (adv_diff > 15'(eff_rows)) ? eff_rows : adv_diff[7:0];

    assign sum_col = 15'(col_reg) + 15'(cnt_p);
    assign tab_col = (col_reg >= eff_cols) ? eff_cols : col_reg + 9'd1;

    assign digit    = in_byte_reg - CH_0;
    assign acc_cur  = second_reg ? p2_reg : p1_reg;
    assign acc_full = 18'(acc_cur) * 18'd10 + 18'(digit[3:0]);
    assign acc_sat  = (acc_full > 18'(PARAM_MAX)) ? PARAM_MAX : acc_full[13:0];

    assign sgr_cur = '{bright: bright_reg, fg: fg_reg, bg: bg_reg};
    assign sgr_one = sgr_apply(sgr_cur, p1_reg);
    assign sgr_two = second_reg ? sgr_apply(sgr_one, p2_reg) : sgr_one;

    assign cfg_wr       = cfg_valid && cfg_ready;
    assign cfg_known    = (cfg_index == CFG_COLUMNS) || (cfg_index == CFG_ROWS);
    assign cfg_cols_eff = clamp_cols((cfg_index == CFG_COLUMNS) ? cfg_data : columns_reg);
    assign cfg_rows_eff = clamp_rows((cfg_index == CFG_ROWS) ? cfg_data[7:0] : rows_reg);
    assign cfg_last_row = 7'(cfg_rows_eff - 8'd1);

    always_comb
    begin
        mode_next     = mode_reg;
        second_next   = second_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        bright_next   = bright_reg;
        fg_next       = fg_reg;
        bg_next       = bg_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        busy_next     = busy_reg;
        drawpend_next = drawpend_reg;
        tab_next      = tab_reg;
        glyph_next    = glyph_reg;
        cnt_next      = cnt_reg;

        emit      = 1'b0;
        done      = 1'b1;
        res_kind  = KIND_CURSOR;
        res_col   = col_reg;
        res_row   = row_reg;
        res_glyph = 8'd0;
        res_lines = 8'd0;

        put_do    = 1'b0;
        put_col   = col_reg;
        put_cnt   = cnt_reg;
        put_glyph = glyph_reg;
        put_tab   = tab_reg;
        put_draw  = drawpend_reg;
        draw_col  = col_reg;
        draw_row  = row_reg;
        draw_ok   = 1'b0;
        col_inc   = col_reg;
        cnt_inc   = cnt_reg;

        if (busy_reg)
        begin
            put_do = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    if (in_byte_reg == CH_LBRK)
                    begin
                        mode_next   = MODE_CSI;
                        p1_next     = 14'd0;
                        p2_next     = 14'd0;
                        second_next = 1'b0;
                    end
                    else
                        mode_next = MODE_GROUND;
                end
                MODE_CSI:
                begin
                    if (in_byte_reg >= CH_0 && in_byte_reg <= CH_9)
                    begin
                        if (second_reg)
                            p2_next = acc_sat;
                        else
                            p1_next = acc_sat;
                    end
                    else if (in_byte_reg == CH_SEMI)
                    begin
                        second_next = 1'b1;
                        p2_next     = 14'd0;
                    end
                    else
                    begin
                        mode_next   = MODE_GROUND;
                        second_next = 1'b0;
                        emit        = 1'b1;
                        unique case (in_byte_reg)
                            CH_A:
                                row_next = ({7'd0, row_reg} > cnt_p) ? row_reg - cnt_p[6:0]
                                                                      : 7'd0;
                            CH_B:
                            begin
                                if (row_reg < last_row)
                                    row_next = (adv_sum > 15'(last_row)) ? last_row
                                                                         : adv_sum[6:0];
                            end
                            CH_C:
                            begin
                                if (col_reg < cols_m1)
                                    col_next = (sum_col > 15'(cols_m1)) ? cols_m1
                                                                        : sum_col[8:0];
                            end
                            CH_D:
                                col_next = ({5'd0, col_reg} > cnt_p) ? col_reg - cnt_p[8:0]
                                                                      : 9'd0;
                            CH_E:
                            begin
                                col_next = 9'd0;
                                if (adv_scroll)
                                begin
                                    row_next  = last_row;
                                    res_kind  = KIND_SCROLL;
                                    res_lines = adv_lines;
                                end
                                else
                                    row_next = adv_sum[6:0];
                            end
                            CH_F:
                            begin
                                col_next = 9'd0;
                                row_next = ({7'd0, row_reg} > cnt_p) ? row_reg - cnt_p[6:0]
                                                                      : 7'd0;
                            end
                            CH_G:
                            begin
                                if (cnt_p <= 14'(eff_cols))
                                    col_next = cnt_m1[8:0];
                            end
                            CH_H, CH_LF_F:
                            begin
                                if (cnt_p <= 14'(eff_rows))
                                    row_next = cnt_m1[6:0];
                                if (x_p <= 14'(eff_cols))
                                    col_next = x_m1[8:0];
                            end
                            CH_J:
                            begin
                                emit = (p1_reg == CLEAR_ALL);
                                res_kind = KIND_CLEAR;
                                if (p1_reg == CLEAR_ALL)
                                begin
                                    col_next = 9'd0;
                                    row_next = 7'd0;
                                end
                            end
                            CH_M:
                            begin
                                emit        = 1'b0;
                                bright_next = sgr_two.bright;
                                fg_next     = sgr_two.fg;
                                bg_next     = sgr_two.bg;
                            end
                            default:
                                emit = 1'b0;
                        endcase
                        res_col = col_next;
                        res_row = row_next;
                    end
                end
                default:
                begin
                    mode_next = MODE_GROUND;
                    unique case (in_byte_reg)
                        CH_ESC:
                            mode_next = MODE_ESC;
                        CH_LF:
                        begin
                            emit     = 1'b1;
                            col_next = 9'd0;
                            res_col  = 9'd0;
                            if (adv_scroll)
                            begin
                                row_next  = last_row;
                                res_kind  = KIND_SCROLL;
                                res_lines = adv_lines;
                            end
                            else
                                row_next = adv_sum[6:0];
                            res_row = row_next;
                        end
                        CH_CR:
                            emit = 1'b0;
                        CH_TAB:
                        begin
                            col_next = tab_col;
                            if ((tab_col % TAB_STOP_W) == 9'd0)
                            begin
                                emit    = 1'b1;
                                res_col = tab_col;
                            end
                            else
                            begin
                                put_do    = 1'b1;
                                put_col   = tab_col;
                                put_cnt   = 4'd0;
                                put_glyph = CH_SPACE;
                                put_tab   = 1'b1;
                                put_draw  = 1'b0;
                            end
                        end
                        CH_BS:
                        begin
                            if (col_reg != 9'd0)
                            begin
                                emit     = 1'b1;
                                res_kind = KIND_ERASE;
                                col_next = col_reg - 9'd1;
                                res_col  = col_reg - 9'd1;
                            end
                        end
                        default:
                        begin
                            put_do    = 1'b1;
                            put_col   = col_reg;
                            put_cnt   = 4'd0;
                            put_glyph = in_byte_reg;
                            put_tab   = 1'b0;
                            put_draw  = 1'b0;
                        end
                    endcase
                end
            endcase
        end

        if (put_do)
        begin
            glyph_next = put_glyph;
            tab_next   = put_tab;
            draw_col   = put_col;
            draw_row   = row_reg;
            draw_ok    = 1'b1;
            cnt_inc    = put_cnt + 4'd1;
            if (!put_draw && put_col >= eff_cols)
            begin
                draw_col = 9'd0;
                if (row_reg == last_row)
                begin
                    // scroll now, draw on a later step if budget remains
                    emit          = 1'b1;
                    res_kind      = KIND_SCROLL;
                    res_col       = 9'd0;
                    res_row       = row_reg;
                    res_lines     = 8'd1;
                    col_next      = 9'd0;
                    cnt_next      = cnt_inc;
                    draw_ok       = 1'b0;
                    busy_next     = cnt_inc < MAX_RESULTS;
                    drawpend_next = 1'b1;
                    done          = !(cnt_inc < MAX_RESULTS);
                end
                else
                    draw_row = row_reg + 7'd1;
            end
            if (draw_ok)
            begin
                col_inc       = draw_col + 9'd1;
                emit          = 1'b1;
                res_kind      = KIND_DRAW;
                res_col       = draw_col;
                res_row       = draw_row;
                res_glyph     = put_glyph;
                col_next      = col_inc;
                row_next      = draw_row;
                cnt_next      = cnt_inc;
                busy_next     = put_tab && ((col_inc % TAB_STOP_W) != 9'd0)
                                && (cnt_inc < MAX_RESULTS);
                drawpend_next = 1'b0;
                done          = !(put_tab && ((col_inc % TAB_STOP_W) != 9'd0)
                                  && (cnt_inc < MAX_RESULTS));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= COLS_RESET;
            rows_reg      <= ROWS_RESET;
            in_vld_reg    <= 1'b0;
            in_byte_reg   <= 8'd0;
            mode_reg      <= MODE_GROUND;
            second_reg    <= 1'b0;
            p1_reg        <= 14'd0;
            p2_reg        <= 14'd0;
            bright_reg    <= 1'b0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_DEFAULT;
            col_reg       <= 9'd0;
            row_reg       <= 7'd0;
            busy_reg      <= 1'b0;
            drawpend_reg  <= 1'b0;
            tab_reg       <= 1'b0;
            glyph_reg     <= 8'd0;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_DRAW;
            out_col_reg   <= 9'd0;
            out_row_reg   <= 7'd0;
            out_glyph_reg <= 8'd0;
            out_fg_reg    <= 4'd0;
            out_bg_reg    <= 5'd0;
            out_lines_reg <= 8'd0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_vld_reg  <= 1'b1;
                in_byte_reg <= s_tdata;
            end
            else if (step && done)
                in_vld_reg <= 1'b0;

            if (step && emit)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= res_kind;
                out_col_reg   <= res_col;
                out_row_reg   <= res_row;
                out_glyph_reg <= res_glyph;
                out_fg_reg    <= fg_reg;
                out_bg_reg    <= bg_reg;
                out_lines_reg <= res_lines;
                out_last_reg  <= done;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg_wr)
            begin
                if (cfg_known)
                begin
                    if (cfg_index == CFG_COLUMNS)
                        columns_reg <= cfg_data;
                    else
                        rows_reg <= cfg_data[7:0];
                    // pull the cursor back inside the new screen
                    if (col_reg > cfg_cols_eff)
                        col_reg <= cfg_cols_eff;
                    if (row_reg > cfg_last_row)
                        row_reg <= cfg_last_row;
                end
            end
            else if (step)
            begin
                mode_reg     <= mode_next;
                second_reg   <= second_next;
                p1_reg       <= p1_next;
                p2_reg       <= p2_next;
                bright_reg   <= bright_next;
                fg_reg       <= fg_next;
                bg_reg       <= bg_next;
                col_reg      <= col_next;
                row_reg      <= row_next;
                busy_reg     <= busy_next;
                drawpend_reg <= drawpend_next;
                tab_reg      <= tab_next;
                glyph_reg    <= glyph_next;
                cnt_reg      <= cnt_next;
            end
        end
    end

    `ACTC_ASSERT_ALWAYS(a_row_on_screen, row_reg <= last_row, "cursor row beyond last row")
    `ACTC_ASSERT_ALWAYS(a_col_in_range, col_reg <= eff_cols, "cursor column beyond row end")
    `ACTC_ASSERT_IMP(a_busy_has_item, busy_reg, in_vld_reg, "sequencer busy without an item")
    `ACTC_ASSERT_IMP(a_fill_only_tab, busy_reg && !drawpend_reg, tab_reg, "fill step outside tab")

endmodule

[test/testbench.sv]
// Self-checking bench for the ANSI/CSI text console unit: drives terminal bytes and
// screen-size writes, predicts every draw/erase/scroll/clear/cursor item and compares.
// Depends on actc_pkg and the ansi_csi_text_console_unit RTL.
`timescale 1ns / 100ps

module testbench;
    import actc_pkg::*;

    localparam int DIRECTED_LEN  = 29;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 18;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLDOFF_LEN   = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_MAX    = 10;

    localparam logic [7:0] MOVE_FINALS [10] =
        '{CH_A, CH_B, CH_C, CH_D, CH_E, CH_F, CH_G, CH_H, CH_LF_F, CH_J};
    // ANSI colour number to palette slot
    localparam logic [2:0] ANSI_ORDER [8] = '{3'd0, 3'd1, 3'd2, 3'd6, 3'd3, 3'd5, 3'd4, 3'd7};

    typedef enum logic [1:0] {
        PARSE_GROUND,
        PARSE_ESC,
        PARSE_CSI
    } parse_mode_e;

    typedef struct packed {
        kind_t      kind;
        logic [8:0] col;
        logic [6:0] row;
        logic [7:0] glyph;
        logic [3:0] fg;
        logic [4:0] bg;
        logic [7:0] lines;
        logic       last;
    } screen_op_t;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        screen_op_t op;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [47:0]            m_tdata;
    logic [2:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [8:0]             cfg_data = '0;

    always #4 clk = ~clk;

    ansi_csi_text_console_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Console model state, matching the block after reset
    int unsigned cols_reg = COLS_RESET;
    int unsigned rows_reg = ROWS_RESET;
    parse_mode_e parse_mode = PARSE_GROUND;
    bit          in_second = 1'b0;
    int unsigned param_a = 0;
    int unsigned param_b = 0;
    bit          bright = 1'b0;
    logic [3:0]  fg_now = FG_RESET;
    logic [4:0]  bg_now = BG_DEFAULT;
    int unsigned cur_col = 0;
    int unsigned cur_row = 0;

    screen_op_t  byte_ops[$];
    screen_op_t  screen_ops_due[$];
    logic [7:0]  stream_bytes[$];

    int unsigned errors = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned holdoff_asked = 0;
    int unsigned holdoff_served = 0;

    function automatic int unsigned screen_cols();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > COLS_MAX)
            return COLS_MAX;
        return cols_reg;
    endfunction

    function automatic int unsigned screen_rows();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > ROWS_MAX)
            return ROWS_MAX;
        return rows_reg;
    endfunction

    function automatic void emit_op(kind_t k, int unsigned col, int unsigned row,
                                    int unsigned glyph, int unsigned lines);
        screen_op_t op;
        if (byte_ops.size() >= MAX_RESULTS)
            return;
        op.kind  = k;
        op.col   = 9'(col);
        op.row   = 7'(row);
        op.glyph = 8'(glyph);
        op.fg    = fg_now;
        op.bg    = bg_now;
        op.lines = 8'(lines);
        op.last  = 1'b0;
        byte_ops.push_back(op);
    endfunction

    // Move down cnt lines to column 0; return how many lines fell off the bottom
    function automatic int unsigned new_lines(int unsigned cnt);
        int unsigned bottom;
        int unsigned r;
        bottom = screen_rows() - 1;
        r = cur_row + cnt;
        cur_col = 0;
        if (r > bottom)
        begin
            cur_row = bottom;
            return r - bottom;
        end
        cur_row = r;
        return 0;
    endfunction

    function automatic void report_lines(int unsigned scrolled);
        if (scrolled != 0)
            emit_op(KIND_SCROLL, cur_col, cur_row, 0,
                    scrolled > screen_rows() ? screen_rows() : scrolled);
        else
            emit_op(KIND_CURSOR, cur_col, cur_row, 0, 0);
    endfunction

    function automatic void draw_glyph(int unsigned g);
        if (cur_col >= screen_cols())
        begin
            if (new_lines(1) != 0)
                emit_op(KIND_SCROLL, cur_col, cur_row, 0, 1);
        end
        if (byte_ops.size() >= MAX_RESULTS)
            return;
        emit_op(KIND_DRAW, cur_col, cur_row, g, 0);
        cur_col++;
    endfunction

    function automatic void apply_sgr(int unsigned v);
        if (v == SGR_RESET)
        begin
            fg_now = FG_RESET;
            bg_now = BG_DEFAULT;
        end
        else if (v == SGR_BRIGHT)
            bright = 1'b1;
        else if (v == SGR_NORMAL)
            bright = 1'b0;
        else if (v >= SGR_FG_LO && v <= SGR_FG_HI)
            fg_now = {bright, ANSI_ORDER[v - SGR_FG_LO]};
        else if (v >= SGR_BG_LO && v <= SGR_BG_HI)
            bg_now = {2'b00, ANSI_ORDER[v - SGR_BG_LO]};
        else if (v >= SGR_BFG_LO && v <= SGR_BFG_HI)
            fg_now = {1'b1, ANSI_ORDER[v - SGR_BFG_LO]};
        else if (v >= SGR_BBG_LO && v <= SGR_BBG_HI)
            bg_now = {2'b01, ANSI_ORDER[v - SGR_BBG_LO]};
    endfunction

    function automatic void csi_final(logic [7:0] c);
        int unsigned ncols;
        int unsigned nrows;
        int unsigned cnt;
        int unsigned x;
        bit          moved;
        ncols = screen_cols();
        nrows = screen_rows();
        cnt = (param_a != 0) ? param_a : 1;
        moved = 1'b1;
        case (c)
            CH_A: cur_row = (cur_row > cnt) ? cur_row - cnt : 0;
            CH_B:
                if (cur_row < nrows - 1)
                    cur_row = (cur_row + cnt > nrows - 1) ? nrows - 1 : cur_row + cnt;
            CH_C:
                if (cur_col < ncols - 1)
                    cur_col = (cur_col + cnt > ncols - 1) ? ncols - 1 : cur_col + cnt;
            CH_D: cur_col = (cur_col > cnt) ? cur_col - cnt : 0;
            CH_E:
            begin
                report_lines(new_lines(cnt));
                moved = 1'b0;
            end
            CH_F:
            begin
                cur_col = 0;
                cur_row = (cur_row > cnt) ? cur_row - cnt : 0;
            end
            CH_G:
                if (cnt <= ncols)
                    cur_col = cnt - 1;
            CH_H, CH_LF_F:
            begin
                x = (param_b != 0) ? param_b : 1;
                if (cnt <= nrows)
                    cur_row = cnt - 1;
                if (x <= ncols)
                    cur_col = x - 1;
            end
            CH_J:
            begin
                if (param_a == CLEAR_ALL)
                begin
                    cur_col = 0;
                    cur_row = 0;
                    emit_op(KIND_CLEAR, 0, 0, 0, 0);
                end
                moved = 1'b0;
            end
            CH_M:
            begin
                apply_sgr(param_a);
                if (in_second)
                    apply_sgr(param_b);
                moved = 1'b0;
            end
            default: moved = 1'b0;
        endcase
        if (moved)
            emit_op(KIND_CURSOR, cur_col, cur_row, 0, 0);
    endfunction

    function automatic void tab_fill();
        bit drawn;
        drawn = 1'b0;
        cur_col++;
        if (cur_col > screen_cols())
            cur_col = screen_cols();
        while ((cur_col % TAB_STOP) != 0 && byte_ops.size() < MAX_RESULTS)
        begin
            draw_glyph(CH_SPACE);
            drawn = 1'b1;
        end
        if (!drawn)
            emit_op(KIND_CURSOR, cur_col, cur_row, 0, 0);
    endfunction

    // Work out the screen ops that one accepted byte causes, into byte_ops
    function automatic void apply_console_byte(logic [7:0] c);
        screen_op_t  op;
        int unsigned acc;
        byte_ops.delete();
        case (parse_mode)
            PARSE_ESC:
                if (c == CH_LBRK)
                begin
                    parse_mode = PARSE_CSI;
                    param_a = 0;
                    param_b = 0;
                    in_second = 1'b0;
                end
                else
                    parse_mode = PARSE_GROUND;
            PARSE_CSI:
                if (c >= CH_0 && c <= CH_9)
                begin
                    acc = (in_second ? param_b : param_a) * 10 + (c - CH_0);
                    if (acc > PARAM_MAX)
                        acc = PARAM_MAX;
                    if (in_second)
                        param_b = acc;
                    else
                        param_a = acc;
                end
                else if (c == CH_SEMI)
                begin
                    in_second = 1'b1;
                    param_b = 0;
                end
                else
                begin
                    parse_mode = PARSE_GROUND;
                    csi_final(c);
                    in_second = 1'b0;
                end
            default:
                if (c == CH_ESC)
                    parse_mode = PARSE_ESC;
                else if (c == CH_LF)
                    report_lines(new_lines(1));
                else if (c == CH_CR)
                    ;
                else if (c == CH_TAB)
                    tab_fill();
                else if (c == CH_BS)
                begin
                    if (cur_col > 0)
                    begin
                        cur_col--;
                        emit_op(KIND_ERASE, cur_col, cur_row, 0, 0);
                    end
                end
                else
                    draw_glyph(c);
        endcase
        if (byte_ops.size() > 0)
        begin
            op = byte_ops.pop_back();
            op.last = 1'b1;
            byte_ops.push_back(op);
        end
    endfunction

    function automatic void resize_screen(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
        if (idx == CFG_COLUMNS)
            cols_reg = val & 'h1FF;
        else if (idx == CFG_ROWS)
            rows_reg = val & 'hFF;
        if (cur_col > screen_cols())
            cur_col = screen_cols();
        if (cur_row > screen_rows() - 1)
            cur_row = screen_rows() - 1;
    endfunction

    function automatic string op_text(screen_op_t o);
        return $sformatf("kind %0d col %0d row %0d glyph %h fg %0d bg %0d lines %0d last %0d",
                         o.kind, o.col, o.row, o.glyph, o.fg, o.bg, o.lines, o.last);
    endfunction

    function automatic void push_number(int unsigned v);
        string s;
        int    i;
        s = $sformatf("%0d", v);
        for (i = 0; i < s.len(); i++)
            stream_bytes.push_back(s[i]);
    endfunction

    // -1 leaves the parameter out
    function automatic int pick_param(int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return -1;
        if (r == 1)
            return $urandom_range(9990, 20000);
        return $urandom_range(0, (r < 6) ? 4 : span);
    endfunction

    function automatic int unsigned pick_sgr();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(SGR_RESET, SGR_NORMAL);
            1:       return $urandom_range(SGR_FG_LO, SGR_FG_HI);
            2:       return $urandom_range(SGR_BG_LO, SGR_BG_HI);
            3:       return $urandom_range(SGR_BFG_LO, SGR_BFG_HI);
            4:       return $urandom_range(SGR_BBG_LO, SGR_BBG_HI);
            default: return $urandom_range(0, SGR_BBG_HI + 13);
        endcase
    endfunction

    // Append one random text run, control, escape sequence or noise to stream_bytes
    function automatic void make_burst();
        int unsigned sel;
        int unsigned n;
        int unsigned span;
        int          a;
        int          b;
        logic [7:0]  c;
        logic [7:0]  fin;
        sel = $urandom_range(0, 99);
        span = ((screen_cols() > screen_rows()) ? screen_cols() : screen_rows()) + 1;
        if (sel < 30)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_ESC || c == CH_LF || c == CH_CR || c == CH_TAB || c == CH_BS);
                stream_bytes.push_back(c);
            end
        end
        else if (sel < 45)
        begin
            case ($urandom_range(0, 3))
                0:       stream_bytes.push_back(CH_LF);
                1:       stream_bytes.push_back(CH_TAB);
                2:       stream_bytes.push_back(CH_BS);
                default: stream_bytes.push_back(CH_CR);
            endcase
        end
        else if (sel < 75)
        begin
            fin = MOVE_FINALS[$urandom_range(0, 9)];
            stream_bytes.push_back(CH_ESC);
            stream_bytes.push_back(CH_LBRK);
            a = (fin == CH_J && $urandom_range(0, 1) == 0) ? int'(CLEAR_ALL) : pick_param(span);
            if (a >= 0)
                push_number(a);
            if ($urandom_range(0, 2) == 0)
            begin
                stream_bytes.push_back(CH_SEMI);
                b = pick_param(span);
                if (b >= 0)
                    push_number(b);
            end
            stream_bytes.push_back(fin);
        end
        else if (sel < 88)
        begin
            stream_bytes.push_back(CH_ESC);
            stream_bytes.push_back(CH_LBRK);
            if ($urandom_range(0, 9) != 0)
                push_number(pick_sgr());
            if ($urandom_range(0, 1) == 0)
            begin
                stream_bytes.push_back(CH_SEMI);
                if ($urandom_range(0, 9) != 0)
                    push_number(pick_sgr());
            end
            stream_bytes.push_back(CH_M);
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:
                    stream_bytes.push_back(8'($urandom_range(0, 255)));
                1:
                begin
                    stream_bytes.push_back(CH_ESC);
                    stream_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    // broken or unknown CSI: stray separators, then any final
                    stream_bytes.push_back(CH_ESC);
                    stream_bytes.push_back(CH_LBRK);
                    repeat ($urandom_range(0, 2))
                        stream_bytes.push_back(CH_SEMI);
                    stream_bytes.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Both registers in one burst so cfg_valid is never dropped and raised in one step
    task automatic set_screen(input int unsigned ncols, input int unsigned nrows);
        int i;
        for (i = 0; i < 2; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? CFG_COLUMNS : CFG_ROWS;
            cfg_data  <= 9'((i == 0) ? ncols : nrows);
            do
                @(posedge clk);
            while (!cfg_ready);
            resize_screen((i == 0) ? CFG_COLUMNS : CFG_ROWS, (i == 0) ? ncols : nrows);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (screen_ops_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned k;
        forever
        begin
            @(posedge clk);
            if (holdoff_asked != holdoff_served)
            begin
                holdoff_served++;
                m_tready <= 1'b0;
                for (k = 0; k < HOLDOFF_LEN; k++)
                    @(posedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        screen_op_t got;
        screen_op_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind  = kind_t'(m_tuser);
            got.col   = m_tdata[8:0];
            got.row   = m_tdata[15:9];
            got.glyph = m_tdata[23:16];
            got.fg    = m_tdata[27:24];
            got.bg    = m_tdata[32:28];
            got.lines = m_tdata[40:33];
            got.last  = m_tlast;
            if (screen_ops_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: unexpected item %s", op_text(got));
            end
            else
            begin
                want = screen_ops_due.pop_front();
                if (got.kind !== want.kind || got.col !== want.col || got.row !== want.row
                    || got.glyph !== want.glyph || got.fg !== want.fg || got.bg !== want.bg
                    || got.lines !== want.lines || got.last !== want.last)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("ERROR: expected %s\n       got      %s",
                                 op_text(want), op_text(got));
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t   directed_rows [DIRECTED_LEN];
        int          i;
        int          phase;
        int unsigned sent;
        int unsigned ncols;
        int unsigned nrows;
        directed_rows = '{
            '{8'h41,   1'b1, '{KIND_DRAW,   9'd0, 7'd0,  8'h41, 4'd0, BG_DEFAULT, 8'd0,  1'b1}},
            '{CH_BS,   1'b1, '{KIND_ERASE,  9'd0, 7'd0,  8'h00, 4'd0, BG_DEFAULT, 8'd0,  1'b1}},
            '{CH_BS,   1'b0, '0},
            '{CH_CR,   1'b0, '0},
            '{8'hFF,   1'b1, '{KIND_DRAW,   9'd0, 7'd0,  8'hFF, 4'd0, BG_DEFAULT, 8'd0,  1'b1}},
            '{CH_TAB,  1'b0, '0},
            '{CH_LF,   1'b1, '{KIND_CURSOR, 9'd0, 7'd1,  8'h00, 4'd0, BG_DEFAULT, 8'd0,  1'b1}},
            '{CH_ESC,  1'b0, '0},
            '{8'h78,   1'b0, '0},
            '{CH_ESC,  1'b0, '0},
            '{CH_LBRK, 1'b0, '0},
            '{CH_9,    1'b0, '0},
            '{CH_9,    1'b0, '0},
            '{CH_9,    1'b0, '0},
            '{CH_9,    1'b0, '0},
            '{CH_9,    1'b0, '0},
            '{CH_SEMI, 1'b0, '0},
            '{CH_SEMI, 1'b0, '0},
            // saturated line count scrolls by the full screen height
            '{CH_E,    1'b1, '{KIND_SCROLL, 9'd0, 7'd24, 8'h00, 4'd0, BG_DEFAULT, 8'd25, 1'b1}},
            '{CH_ESC,  1'b0, '0},
            '{CH_LBRK, 1'b0, '0},
            '{8'h32,   1'b0, '0},
            '{CH_J,    1'b1, '{KIND_CLEAR,  9'd0, 7'd0,  8'h00, 4'd0, BG_DEFAULT, 8'd0,  1'b1}},
            '{CH_ESC,  1'b0, '0},
            '{CH_LBRK, 1'b0, '0},
            '{CH_9,    1'b0, '0},
            '{8'h37,   1'b0, '0},
            '{CH_M,    1'b0, '0},
            '{8'h00,   1'b0, '0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_LEN; i++)
        begin
            send_byte(directed_rows[i].data);
            apply_console_byte(directed_rows[i].data);
            if (directed_rows[i].typed)
                screen_ops_due.push_back(directed_rows[i].op);
            else
                foreach (byte_ops[j])
                    screen_ops_due.push_back(byte_ops[j]);
        end
        s_tvalid <= 1'b0;
        drain();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    ncols = 1;
                    nrows = 1;
                end
                1:
                begin
                    ncols = COLS_MAX;
                    nrows = ROWS_MAX;
                end
                2:
                begin
                    ncols = 9;
                    nrows = 3;
                end
                3:
                begin
                    ncols = $urandom_range(1, 16);
                    nrows = $urandom_range(1, 6);
                end
                4:
                begin
                    ncols = 255;
                    nrows = 127;
                end
                default:
                begin
                    ncols = $urandom_range(1, 40);
                    nrows = $urandom_range(1, 8);
                end
            endcase
            set_screen(ncols, nrows);
            sender_idle_pct    = (phase % 4 == 1) ? 63 : (phase % 4 == 3) ? 32 : 0;
            receiver_stall_pct = (phase % 4 == 2) ? 63 : (phase % 4 == 3) ? 32 : 0;
            // hold the receiver off while bytes keep coming, so the block backs up
            if (phase == 2)
                holdoff_asked++;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                stream_bytes.delete();
                make_burst();
                foreach (stream_bytes[j])
                begin
                    send_byte(stream_bytes[j]);
                    apply_console_byte(stream_bytes[j]);
                    foreach (byte_ops[k])
                        screen_ops_due.push_back(byte_ops[k]);
                end
                sent += stream_bytes.size();
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (errors == 0 && screen_ops_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
